// ===== design/rtr_pkg.sv =====
// shared types, constants and sequence arithmetic for the transfer receiver
`default_nettype none

package rtr_pkg;

  localparam int unsigned HOLD_DEPTH  = 16;
  localparam int unsigned SEQ_MAX     = 25600;
  localparam int unsigned MAX_PAYLOAD = 512;

  localparam int unsigned SEQ_W  = 15;
  localparam int unsigned SIZE_W = 10;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned KIND_W = 3;

  localparam int unsigned HOLD_AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int unsigned HOLD_CW = $clog2(HOLD_DEPTH + 1);

  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int unsigned SUM_W = SEQ_W + 2;
  localparam logic [SUM_W-1:0]  SEQ_MOD  = SUM_W'(SEQ_MAX + 1);
  localparam logic [SIZE_W-1:0] SIZE_SAT = SIZE_W'(MAX_PAYLOAD);

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [0:0]  REG_INIT_SEQ = 1'b0;
  localparam logic [SEQ_W-1:0] INIT_SEQ_RST = SEQ_W'(7706);

  typedef enum logic [KIND_W-1:0] {
    KIND_SYNACK  = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_FIN     = 3'd2,
    KIND_DELIVER = 3'd3,
    KIND_STATUS  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CMD_SYN  = 2'd0,
    CMD_FIN  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_cls_e;

  typedef struct packed {
    cmd_cls_e          cls;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  seq_inc;
    logic [SEQ_W-1:0]  ack;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } hold_t;

  typedef struct packed {
    kind_e             kind;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] bytes;
    logic              ok;
    logic              ovf;
    logic              last;
  } res_t;

  // sum of a sequence number and a byte count, wrapped into the sequence space
  function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0]  a,
                                               input logic [SIZE_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SEQ_MOD) begin
      s = s - SEQ_MOD;
    end
    return s[SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/reliable_transfer_receiver.sv =====
// top level of the transfer receiver: config register, front, queue and back
//
//  channel   direction  handshake                        payload
//  in        sink       in_valid_i / in_ready_o          syn, fin, seq, ack, size, tag
//  out       source     out_valid_o / out_ready_i        kind, seq, ack, tag, bytes, flags
//  config    apb        psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// a header is taken into a two-entry command queue in the cycle it arrives;
// the back handles one header at a time: syn, handshake, close and dropped data
// in B_IDLE alone, fin then in B_FIN, out-of-order data then in B_ACK, and
// in-order data then in B_RDREQ and B_DRAIN per hold entry read (registered
// hold memory read) and last in B_ACK. one result leaves per cycle through the
// output register; a stalled output stalls the back, and the queue keeps taking
// headers until it is full. reset is asynchronous and needs no clearing pass.
`default_nettype none

module reliable_transfer_receiver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rtr_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [rtr_pkg::CFG_DW-1:0]  pwdata,
  output logic      [rtr_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        syn_bit_i,
  input  wire logic                        fin_bit_i,
  input  wire logic [rtr_pkg::SEQ_W-1:0]   seq_num_i,
  input  wire logic [rtr_pkg::SEQ_W-1:0]   ack_num_i,
  input  wire logic [rtr_pkg::SIZE_W-1:0]  data_size_i,
  input  wire logic [rtr_pkg::TAG_W-1:0]   payload_tag_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [rtr_pkg::KIND_W-1:0]  kind_o,
  output logic      [rtr_pkg::SEQ_W-1:0]   out_seq_o,
  output logic      [rtr_pkg::SEQ_W-1:0]   out_ack_o,
  output logic      [rtr_pkg::TAG_W-1:0]   deliver_tag_o,
  output logic      [rtr_pkg::SIZE_W-1:0]  deliver_bytes_o,
  output logic                             handshake_ok_o,
  output logic                             hold_overflow_o,
  output logic                             last_o
);

  logic [rtr_pkg::SEQ_W-1:0] init_seq_q;
  logic                      cfg_wr;
  logic                      q_full, q_push, q_valid, q_pop;
  rtr_pkg::cmd_t             front_cmd, head_cmd;
  rtr_pkg::res_t             res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rtr_pkg::REG_INIT_SEQ);
  assign prdata = (paddr[2] == rtr_pkg::REG_INIT_SEQ) ? rtr_pkg::CFG_DW'(init_seq_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_seq_q <= rtr_pkg::INIT_SEQ_RST;
    end else if (cfg_wr) begin
      init_seq_q <= pwdata[rtr_pkg::SEQ_W-1:0];
    end
  end

  rtr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .syn_bit_i     (syn_bit_i),
    .fin_bit_i     (fin_bit_i),
    .seq_num_i     (seq_num_i),
    .ack_num_i     (ack_num_i),
    .data_size_i   (data_size_i),
    .payload_tag_i (payload_tag_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (front_cmd)
  );

  rtr_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  rtr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (q_pop),
    .init_seq_i  (init_seq_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign out_seq_o       = res.seq;
  assign out_ack_o       = res.ack;
  assign deliver_tag_o   = res.tag;
  assign deliver_bytes_o = res.bytes;
  assign handshake_ok_o  = res.ok;
  assign hold_overflow_o = res.ovf;
  assign last_o          = res.last;

endmodule

`default_nettype wire

// ===== design/rtr_front.sv =====
// input side: takes packet headers, classifies them and saturates the size
`default_nettype none

module rtr_front (
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       syn_bit_i,
  input  wire logic                       fin_bit_i,
  input  wire logic [rtr_pkg::SEQ_W-1:0]  seq_num_i,
  input  wire logic [rtr_pkg::SEQ_W-1:0]  ack_num_i,
  input  wire logic [rtr_pkg::SIZE_W-1:0] data_size_i,
  input  wire logic [rtr_pkg::TAG_W-1:0]  payload_tag_i,
  input  wire logic                       q_full_i,
  output logic                            push_o,
  output rtr_pkg::cmd_t                   cmd_o
);

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o = '0;
    // syn wins over fin
    if (syn_bit_i) begin
      cmd_o.cls = rtr_pkg::CMD_SYN;
    end else if (fin_bit_i) begin
      cmd_o.cls = rtr_pkg::CMD_FIN;
    end else begin
      cmd_o.cls = rtr_pkg::CMD_DATA;
    end
    cmd_o.seq     = seq_num_i;
    cmd_o.seq_inc = rtr_pkg::seq_add(seq_num_i, rtr_pkg::SIZE_W'(1));
    cmd_o.ack     = ack_num_i;
    cmd_o.size    = (data_size_i > rtr_pkg::SIZE_SAT) ? rtr_pkg::SIZE_SAT : data_size_i;
    cmd_o.tag     = payload_tag_i;
  end

endmodule

`default_nettype wire

// ===== design/rtr_cmd_queue.sv =====
// short command queue between the front and the back
`default_nettype none

module rtr_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rtr_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output rtr_pkg::cmd_t      cmd_o
);

  rtr_pkg::cmd_t                 slot_q [rtr_pkg::CMDQ_DEPTH];
  logic [rtr_pkg::CMDQ_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [rtr_pkg::CMDQ_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [rtr_pkg::CMDQ_CW-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == rtr_pkg::CMDQ_CW'(rtr_pkg::CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rtr_pkg::CMDQ_AW'(rtr_pkg::CMDQ_DEPTH - 1)) ? '0
                 : wr_ptr_q + rtr_pkg::CMDQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rtr_pkg::CMDQ_AW'(rtr_pkg::CMDQ_DEPTH - 1)) ? '0
                 : rd_ptr_q + rtr_pkg::CMDQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + rtr_pkg::CMDQ_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - rtr_pkg::CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rtr_back.sv =====
// connection state, hold fifo and result sequencing
`default_nettype none

module rtr_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  input  wire rtr_pkg::cmd_t             cmd_i,
  output logic                           pop_o,
  input  wire logic [rtr_pkg::SEQ_W-1:0] init_seq_i,
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output rtr_pkg::res_t                  res_o
);

  typedef enum logic [3:0] {
    CONN_IDLE  = 4'b0001,
    CONN_WAIT  = 4'b0010,
    CONN_OPEN  = 4'b0100,
    CONN_CLOSE = 4'b1000
  } conn_e;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_FIN   = 5'b00010,
    B_RDREQ = 5'b00100,
    B_DRAIN = 5'b01000,
    B_ACK   = 5'b10000
  } back_state_e;

  back_state_e                   state_q, state_d;
  conn_e                         conn_q, conn_d;
  logic [rtr_pkg::SEQ_W-1:0]     exp_q, exp_d;
  logic [rtr_pkg::SEQ_W-1:0]     srv_q, srv_d;
  logic [rtr_pkg::HOLD_AW-1:0]   head_q, head_d;
  logic [rtr_pkg::HOLD_CW-1:0]   count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic                          out_valid_q, out_valid_d;
  rtr_pkg::res_t                 res_q, res_d;
  logic                          emit, slot_free;

  rtr_pkg::hold_t                hold_mem [rtr_pkg::HOLD_DEPTH];
  rtr_pkg::hold_t                rd_q, wr_entry;
  logic                          wr_en, rd_en;
  logic [rtr_pkg::HOLD_CW:0]     tail_sum, head_sum;
  logic [rtr_pkg::HOLD_AW-1:0]   tail, head_inc;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // ring positions for depths that are not a power of two
  always_comb begin
    tail_sum = (rtr_pkg::HOLD_CW + 1)'(head_q) + (rtr_pkg::HOLD_CW + 1)'(count_q);
    if (tail_sum >= (rtr_pkg::HOLD_CW + 1)'(rtr_pkg::HOLD_DEPTH)) begin
      tail_sum = tail_sum - (rtr_pkg::HOLD_CW + 1)'(rtr_pkg::HOLD_DEPTH);
    end
    tail = tail_sum[rtr_pkg::HOLD_AW-1:0];
    head_sum = (rtr_pkg::HOLD_CW + 1)'(head_q) + (rtr_pkg::HOLD_CW + 1)'(1);
    if (head_sum >= (rtr_pkg::HOLD_CW + 1)'(rtr_pkg::HOLD_DEPTH)) begin
      head_sum = '0;
    end
    head_inc = head_sum[rtr_pkg::HOLD_AW-1:0];
  end

  assign wr_entry.seq  = cmd_i.seq;
  assign wr_entry.size = cmd_i.size;
  assign wr_entry.tag  = cmd_i.tag;

  always_comb begin
    state_d = state_q;
    conn_d  = conn_q;
    exp_d   = exp_q;
    srv_d   = srv_q;
    head_d  = head_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    res_d   = '0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          if (conn_q == CONN_WAIT) begin
            // any packet here is taken as the handshake ack
            if (slot_free) begin
              emit       = 1'b1;
              res_d.kind = rtr_pkg::KIND_STATUS;
              res_d.seq  = srv_q;
              res_d.ok   = (cmd_i.ack == srv_q);
              res_d.last = 1'b1;
              pop_o      = 1'b1;
              if (cmd_i.ack == srv_q) begin
                exp_d  = cmd_i.seq;
                conn_d = CONN_OPEN;
              end else begin
                conn_d = CONN_IDLE;
              end
            end
          end else if (conn_q == CONN_CLOSE) begin
            conn_d  = CONN_IDLE;
            head_d  = '0;
            count_d = '0;
            pop_o   = 1'b1;
          end else if (cmd_i.cls == rtr_pkg::CMD_SYN) begin
            if (slot_free) begin
              emit       = 1'b1;
              res_d.kind = rtr_pkg::KIND_SYNACK;
              res_d.seq  = init_seq_i;
              res_d.ack  = cmd_i.seq_inc;
              res_d.last = 1'b1;
              srv_d      = init_seq_i + rtr_pkg::SEQ_W'(1);
              conn_d     = CONN_WAIT;
              pop_o      = 1'b1;
            end
          end else if (cmd_i.cls == rtr_pkg::CMD_FIN) begin
            if (slot_free) begin
              emit       = 1'b1;
              res_d.kind = rtr_pkg::KIND_ACK;
              res_d.seq  = srv_q;
              res_d.ack  = cmd_i.seq_inc;
              conn_d     = CONN_CLOSE;
              pop_o      = 1'b1;
              state_d    = B_FIN;
            end
          end else if (conn_q == CONN_OPEN) begin
            if (cmd_i.seq == exp_q) begin
              if (cmd_i.size == '0 || slot_free) begin
                if (cmd_i.size != '0) begin
                  emit        = 1'b1;
                  res_d.kind  = rtr_pkg::KIND_DELIVER;
                  res_d.tag   = cmd_i.tag;
                  res_d.bytes = cmd_i.size;
                end
                exp_d   = rtr_pkg::seq_add(exp_q, cmd_i.size);
                ovf_d   = 1'b0;
                pop_o   = 1'b1;
                state_d = (count_q != '0) ? B_RDREQ : B_ACK;
              end
            end else begin
              pop_o   = 1'b1;
              state_d = B_ACK;
              if (count_q < rtr_pkg::HOLD_CW'(rtr_pkg::HOLD_DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + rtr_pkg::HOLD_CW'(1);
                ovf_d   = 1'b0;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end else begin
            // data with no connection is dropped
            pop_o = 1'b1;
          end
        end
      end
      B_FIN: begin
        if (slot_free) begin
          emit       = 1'b1;
          res_d.kind = rtr_pkg::KIND_FIN;
          res_d.seq  = srv_q;
          res_d.last = 1'b1;
          state_d    = B_IDLE;
        end
      end
      B_RDREQ: begin
        rd_en   = 1'b1;
        state_d = B_DRAIN;
      end
      B_DRAIN: begin
        if (rd_q.seq == exp_q) begin
          if (rd_q.size == '0 || slot_free) begin
            if (rd_q.size != '0) begin
              emit        = 1'b1;
              res_d.kind  = rtr_pkg::KIND_DELIVER;
              res_d.tag   = rd_q.tag;
              res_d.bytes = rd_q.size;
            end
            exp_d   = rtr_pkg::seq_add(exp_q, rd_q.size);
            head_d  = head_inc;
            count_d = count_q - rtr_pkg::HOLD_CW'(1);
            state_d = (count_q > rtr_pkg::HOLD_CW'(1)) ? B_RDREQ : B_ACK;
          end
        end else begin
          state_d = B_ACK;
        end
      end
      B_ACK: begin
        if (slot_free) begin
          emit       = 1'b1;
          res_d.kind = rtr_pkg::KIND_ACK;
          res_d.seq  = srv_q;
          res_d.ack  = exp_q;
          res_d.ovf  = ovf_q;
          res_d.last = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      conn_q      <= CONN_IDLE;
      exp_q       <= '0;
      srv_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      conn_q      <= conn_d;
      exp_q       <= exp_d;
      srv_q       <= srv_d;
      head_q      <= head_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  // hold fifo storage, registered read of the front entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hold_mem[tail] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= hold_mem[head_q];
    end
  end

endmodule

`default_nettype wire

// ===== design/rtr_checker.sv =====
// port-level checks on the result channel of the transfer receiver
`default_nettype none

module rtr_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [rtr_pkg::KIND_W-1:0] kind_o,
  input wire logic [rtr_pkg::SEQ_W-1:0]  out_seq_o,
  input wire logic [rtr_pkg::SIZE_W-1:0] deliver_bytes_o,
  input wire logic                       handshake_ok_o,
  input wire logic                       hold_overflow_o,
  input wire logic                       last_o
);

  // a stalled transfer keeps its header
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(out_seq_o))
    else $error("result changed while stalled");

  // empty payloads are never delivered
  a_no_empty_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rtr_pkg::KIND_DELIVER |-> deliver_bytes_o != '0)
    else $error("deliver with zero bytes");

  // overflow flag only on the closing ack of a packet
  a_ovf_on_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hold_overflow_o |-> kind_o == rtr_pkg::KIND_ACK && last_o)
    else $error("overflow flag on wrong result");

  // handshake status is the only result that may report ok
  a_ok_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && handshake_ok_o |-> kind_o == rtr_pkg::KIND_STATUS && last_o)
    else $error("handshake ok outside status");

  // fin closes the burst of results
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rtr_pkg::KIND_FIN |-> last_o)
    else $error("fin not last");

endmodule

bind reliable_transfer_receiver rtr_checker u_rtr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .out_seq_o       (out_seq_o),
  .deliver_bytes_o (deliver_bytes_o),
  .handshake_ok_o  (handshake_ok_o),
  .hold_overflow_o (hold_overflow_o),
  .last_o          (last_o)
);

`default_nettype wire
